// ===== src/c65x_pkg.sv =====
// ----------------------------------------------------------------------------
// c65x_pkg
// Shared types and constants for the 6502 data execute block.
// ----------------------------------------------------------------------------
package c65x_pkg;

    localparam int unsigned InDataW  = 16;
    localparam int unsigned OutDataW = 48;

    localparam logic [7:0] SpReset   = 8'hFD;
    localparam logic [5:0] FlagReset = 6'h04;

    // flag bit positions
    localparam int unsigned FlC = 0;
    localparam int unsigned FlZ = 1;
    localparam int unsigned FlI = 2;
    localparam int unsigned FlD = 3;
    localparam int unsigned FlV = 4;
    localparam int unsigned FlN = 5;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] xreg;
        logic [7:0] yreg;
        logic [7:0] sp;
        logic [5:0] flags;
    } t_regs;

endpackage

// ===== src/cpu6502_data_execute.sv =====
// ----------------------------------------------------------------------------
// cpu6502_data_execute
// Binary-mode 6502 data path: loads, stores, ALU, shifts, transfers, flags.
// ----------------------------------------------------------------------------
// The result is registered on the output register in the cycle after acceptance.
// Throughput: one request per cycle unless the output stalls; the register
// file feeds back in one pass. Output stage holds a result while stalled;
// input is taken when the output register is empty or being drained.
// Reset: A, X, Y = 0, SP = 0xFD, flags = I only; output register empty.
module cpu6502_data_execute (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [c65x_pkg::InDataW-1:0]  s_axis_tdata,  // req_type, operand
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // store_data, store_enable, acc_out, xreg_out, yreg_out, stack_out,
    // flags_out, handled
    output logic [c65x_pkg::OutDataW-1:0] m_axis_tdata
);
    import c65x_pkg::*;

    t_regs       r_regs, n_regs;
    logic        r_valid;
    logic [7:0]  r_sd;
    logic        r_se, r_hit;
    logic [7:0]  n_sd;
    logic        n_se, n_hit;
    logic        w_acc_in;

    logic [7:0] op, m;
    assign op = s_axis_tdata[7:0];
    assign m  = s_axis_tdata[15:8];

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign w_acc_in      = s_axis_tvalid && s_axis_tready;

    function automatic logic [5:0] nz(input logic [5:0] f, input logic [7:0] v);
        logic [5:0] g;
        g = f;
        g[FlN] = v[7];
        g[FlZ] = (v == 8'h00);
        return g;
    endfunction

    always_comb begin
        logic [7:0] a, x, y, s, t, sh, adm;
        logic [5:0] f;
        logic [8:0] sum, dif;
        logic       doadd, sh_c;
        a = r_regs.acc; x = r_regs.xreg; y = r_regs.yreg; s = r_regs.sp;
        f = r_regs.flags;
        n_sd = 8'h00; n_se = 1'b0; n_hit = 1'b1;
        doadd = 1'b0; adm = 8'h00; t = 8'h00; sh = 8'h00; sh_c = 1'b0;
        sum = 9'h000; dif = 9'h000;
        // shared shifter on the memory operand (accumulator forms shift A separately)
        case (op[7:5])
            3'd0: begin sh = {m[6:0], 1'b0};  sh_c = m[7]; end
            3'd1: begin sh = {m[6:0], f[FlC]}; sh_c = m[7]; end
            3'd2: begin sh = {1'b0, m[7:1]};  sh_c = m[0]; end
            default: begin sh = {f[FlC], m[7:1]}; sh_c = m[0]; end
        endcase
        case (op)
            8'hA9, 8'hA5, 8'hAD, 8'hB5, 8'hBD, 8'hB9, 8'hA1, 8'hB1: begin
                a = m; f = nz(f, m); end
            8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: begin x = m; f = nz(f, m); end
            8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: begin y = m; f = nz(f, m); end
            8'h85, 8'h8D, 8'h95, 8'h9D, 8'h99, 8'h81, 8'h91: begin
                n_sd = a; n_se = 1'b1; end
            8'h86, 8'h8E, 8'h96: begin n_sd = x; n_se = 1'b1; end
            8'h84, 8'h8C, 8'h94: begin n_sd = y; n_se = 1'b1; end
            8'h87, 8'h97, 8'h83, 8'h8F: begin n_sd = a & x; n_se = 1'b1; end
            8'h69, 8'h65, 8'h6D, 8'h75, 8'h7D, 8'h79, 8'h61, 8'h71: begin
                doadd = 1'b1; adm = m; end
            8'hE9, 8'hE5, 8'hED, 8'hF5, 8'hFD, 8'hF9, 8'hE1, 8'hF1, 8'hEB: begin
                doadd = 1'b1; adm = ~m; end
            8'hE0, 8'hE4, 8'hEC: begin
                dif = {1'b0, x} - {1'b0, m}; f[FlC] = !dif[8]; f = nz(f, dif[7:0]); end
            8'hC0, 8'hC4, 8'hCC: begin
                dif = {1'b0, y} - {1'b0, m}; f[FlC] = !dif[8]; f = nz(f, dif[7:0]); end
            8'hC9, 8'hC5, 8'hCD, 8'hD5, 8'hDD, 8'hD9, 8'hC1, 8'hD1: begin
                dif = {1'b0, a} - {1'b0, m}; f[FlC] = !dif[8]; f = nz(f, dif[7:0]); end
            8'h29, 8'h25, 8'h2D, 8'h35, 8'h3D, 8'h39, 8'h21, 8'h31: begin
                a = a & m; f = nz(f, a); end
            8'h49, 8'h45, 8'h4D, 8'h55, 8'h5D, 8'h59, 8'h41, 8'h51: begin
                a = a ^ m; f = nz(f, a); end
            8'h09, 8'h05, 8'h0D, 8'h15, 8'h1D, 8'h19, 8'h01, 8'h11: begin
                a = a | m; f = nz(f, a); end
            8'h24, 8'h2C: begin
                f[FlZ] = ((a & m) == 8'h00); f[FlN] = m[7]; f[FlV] = m[6]; end
            8'h0A: begin f[FlC] = a[7]; a = {a[6:0], 1'b0}; f = nz(f, a); end
            8'h4A: begin f[FlC] = a[0]; a = {1'b0, a[7:1]}; f = nz(f, a); end
            8'h2A: begin t = {a[6:0], f[FlC]}; f[FlC] = a[7]; a = t; f = nz(f, a); end
            8'h6A: begin t = {f[FlC], a[7:1]}; f[FlC] = a[0]; a = t; f = nz(f, a); end
            8'h06, 8'h0E, 8'h16, 8'h1E, 8'h46, 8'h4E, 8'h56, 8'h5E,
            8'h26, 8'h2E, 8'h36, 8'h3E, 8'h66, 8'h6E, 8'h76, 8'h7E: begin
                n_sd = sh; n_se = 1'b1; f[FlC] = sh_c; f = nz(f, sh); end
            8'hE6, 8'hEE, 8'hF6, 8'hFE: begin
                n_sd = m + 8'd1; n_se = 1'b1; f = nz(f, n_sd); end
            8'hC6, 8'hCE, 8'hD6, 8'hDE: begin
                n_sd = m - 8'd1; n_se = 1'b1; f = nz(f, n_sd); end
            8'h07, 8'h17, 8'h03, 8'h13, 8'h0F, 8'h1F, 8'h1B: begin
                n_sd = sh; n_se = 1'b1; f[FlC] = sh_c; a = a | sh; f = nz(f, a); end
            8'h27, 8'h37, 8'h23, 8'h33, 8'h2F, 8'h3F, 8'h3B: begin
                n_sd = sh; n_se = 1'b1; f[FlC] = sh_c; a = a & sh; f = nz(f, a); end
            8'h47, 8'h57, 8'h43, 8'h53, 8'h4F, 8'h5F, 8'h5B: begin
                n_sd = sh; n_se = 1'b1; f[FlC] = sh_c; a = a ^ sh; f = nz(f, a); end
            8'h67, 8'h77, 8'h63, 8'h73, 8'h6F, 8'h7F, 8'h7B: begin
                // rotate carry feeds the add
                n_sd = sh; n_se = 1'b1; f[FlC] = sh_c; doadd = 1'b1; adm = sh; end
            8'hC7, 8'hD7, 8'hC3, 8'hD3, 8'hCF, 8'hDF, 8'hDB: begin
                n_sd = m - 8'd1; n_se = 1'b1;
                dif = {1'b0, a} - {1'b0, n_sd}; f[FlC] = !dif[8]; f = nz(f, dif[7:0]); end
            8'hE7, 8'hF7, 8'hE3, 8'hF3, 8'hEF, 8'hFF, 8'hFB: begin
                n_sd = m + 8'd1; n_se = 1'b1; doadd = 1'b1; adm = ~n_sd; end
            8'hA7, 8'hB7, 8'hA3, 8'hB3, 8'hAF, 8'hBF, 8'hAB: begin
                a = m; x = m; f = nz(f, m); end
            8'h0B, 8'h2B: begin a = a & m; f = nz(f, a); f[FlC] = a[7]; end
            8'h4B: begin t = a & m; f[FlC] = t[0]; a = {1'b0, t[7:1]}; f = nz(f, a); end
            8'h8B: begin a = x & m; f = nz(f, a); end
            8'hCB: begin
                dif = {1'b0, a & x} - {1'b0, m}; f[FlC] = !dif[8];
                x = dif[7:0]; f = nz(f, x); end
            8'hBB: begin a = m & s; x = a; s = a; f = nz(f, a); end
            8'h18: f[FlC] = 1'b0;
            8'h38: f[FlC] = 1'b1;
            8'h58: f[FlI] = 1'b0;
            8'h78: f[FlI] = 1'b1;
            8'hB8: f[FlV] = 1'b0;
            8'hD8: f[FlD] = 1'b0;
            8'hF8: f[FlD] = 1'b1;
            8'hAA: begin x = a; f = nz(f, x); end
            8'h8A: begin a = x; f = nz(f, a); end
            8'hCA: begin x = x - 8'd1; f = nz(f, x); end
            8'hE8: begin x = x + 8'd1; f = nz(f, x); end
            8'hA8: begin y = a; f = nz(f, y); end
            8'h98: begin a = y; f = nz(f, a); end
            8'h88: begin y = y - 8'd1; f = nz(f, y); end
            8'hC8: begin y = y + 8'd1; f = nz(f, y); end
            8'h9A: s = x;
            8'hBA: begin x = s; f = nz(f, x); end
            8'hEA, 8'h04, 8'h44, 8'h64, 8'h0C, 8'h14, 8'h34, 8'h54, 8'h74, 8'hD4,
            8'hF4, 8'h1A, 8'h3A, 8'h5A, 8'h7A, 8'hDA, 8'hFA, 8'h80, 8'h82, 8'h89,
            8'hC2, 8'hE2, 8'h1C, 8'h3C, 8'h5C, 8'h7C, 8'hDC, 8'hFC: ;
            default: n_hit = 1'b0;
        endcase
        if (doadd) begin
            sum = {1'b0, a} + {1'b0, adm} + {8'h00, f[FlC]};
            f[FlV] = (~(a[7] ^ adm[7])) & (a[7] ^ sum[7]);
            f[FlC] = sum[8];
            a = sum[7:0];
            f = nz(f, a);
        end
        n_regs = '{acc: a, xreg: x, yreg: y, sp: s, flags: f};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs  <= '{acc: 8'h00, xreg: 8'h00, yreg: 8'h00, sp: SpReset,
                         flags: FlagReset};
            r_valid <= 1'b0;
        end else begin
            if (w_acc_in) begin
                r_regs  <= n_regs;
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_sd  <= n_sd;
            r_se  <= n_se;
            r_hit <= n_hit;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {r_hit, r_regs.flags, r_regs.sp, r_regs.yreg,
                            r_regs.xreg, r_regs.acc, r_se, r_sd};

    // a foreign opcode leaves the register file untouched
    a_foreign_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_in && !n_hit) |=> (r_regs == $past(r_regs)))
        else $error("foreign opcode changed state");
    // no store request without a handled opcode
    a_store_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_se) |-> r_hit)
        else $error("store without handled");
    // stalled output keeps its request
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result lost under stall");
endmodule
